// File: hw/rtl/lpsp_pkg.sv
// ----------------------------------------------------------------------------
// lpsp_pkg
// Shared constants, codes and pattern tables for the LED chaser with PWM dimming.
// ----------------------------------------------------------------------------
package lpsp_pkg;

	// field widths
	localparam int unsigned INTERVAL_W = 11;
	localparam int unsigned DUTY_W     = 7;
	localparam int unsigned LED_W      = 8;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned STEP_W     = 3;
	localparam int unsigned TICK_W     = 14;
	localparam int unsigned PWM_W      = 7;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned OUT_DATA_W = 16;

	localparam logic [TICK_W-1:0]     TICK_MAX         = 14'd16383;
	localparam logic [PWM_W-1:0]      PWM_WRAP         = 7'd100;
	localparam logic [INTERVAL_W-1:0] INTERVAL_DEFAULT = 11'd400;

	// pattern codes
	localparam logic [MODE_W-1:0] MODE_WALK_LEFT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WALK_RIGHT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PAIR_IN    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_PAIR_OUT   = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WALK_LEFT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WALK_RIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR_IN    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR_OUT   = 2'd3;

	// steps per pattern
	localparam logic [STEP_W:0] STEPS_WALK = 4'd8;
	localparam logic [STEP_W:0] STEPS_PAIR = 4'd4;

	function automatic logic [LED_W-1:0] pair_in_mask(input logic [1:0] s);
		logic [LED_W-1:0] m;
		case (s)
			2'd0:    m = 8'h81;
			2'd1:    m = 8'h42;
			2'd2:    m = 8'h24;
			default: m = 8'h18;
		endcase
		return m;
	endfunction

	function automatic logic [LED_W-1:0] pair_out_mask(input logic [1:0] s);
		logic [LED_W-1:0] m;
		case (s)
			2'd0:    m = 8'h18;
			2'd1:    m = 8'h24;
			2'd2:    m = 8'h42;
			default: m = 8'h81;
		endcase
		return m;
	endfunction

endpackage

// File: hw/rtl/lpsp_mask.sv
// ----------------------------------------------------------------------------
// lpsp_mask
// Lit-LED mask for a given pattern and step.
// ----------------------------------------------------------------------------
module lpsp_mask (
	input  logic [lpsp_pkg::MODE_W-1:0] mode,
	input  logic [lpsp_pkg::STEP_W-1:0] step,
	output logic [lpsp_pkg::LED_W-1:0]  mask
);

	always_comb begin
		case (mode)
			lpsp_pkg::MODE_WALK_LEFT:  mask = 8'h01 << step;
			lpsp_pkg::MODE_WALK_RIGHT: mask = 8'h80 >> step;
			lpsp_pkg::MODE_PAIR_IN:    mask = lpsp_pkg::pair_in_mask(step[1:0]);
			default:                   mask = lpsp_pkg::pair_out_mask(step[1:0]);
		endcase
	end

endmodule

// File: hw/rtl/led_pattern_sequencer_pwm.sv
// Output: a result is valid on m_tvalid in the cycle after its tick is transferred in.
// Throughput: one tick per cycle; the single output register is refilled in the
// same cycle it is drained, so s_tready only drops while a result waits unread.
// Reset: counters, pattern and step clear to zero, intervals return to 400 ms,
// and the output register is empty.
// ----------------------------------------------------------------------------
// led_pattern_sequencer_pwm
// LED chaser with four patterns, per-pattern step interval and PWM dimming.
// ----------------------------------------------------------------------------
module led_pattern_sequencer_pwm (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [lpsp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lpsp_pkg::INTERVAL_W-1:0]     cfg_data,
	// tick input
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [lpsp_pkg::IN_DATA_W-1:0]      s_tdata,   // run, duty[6:0], restart, zero pad
	// LED output
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [lpsp_pkg::OUT_DATA_W-1:0]     m_tdata    // led_drive[7:0], pattern_now[1:0], zero pad
);

	logic [lpsp_pkg::INTERVAL_W-1:0] interval_q [4];
	logic [lpsp_pkg::TICK_W-1:0]     tick_q;
	logic [lpsp_pkg::PWM_W-1:0]      pwm_q;
	logic [lpsp_pkg::MODE_W-1:0]     mode_q;
	logic [lpsp_pkg::STEP_W-1:0]     step_q;
	logic                            out_valid_q;
	logic [lpsp_pkg::LED_W-1:0]      led_q;
	logic [lpsp_pkg::MODE_W-1:0]     pat_out_q;

	logic                            in_xfer;
	logic                            run;
	logic [lpsp_pkg::DUTY_W-1:0]     duty;
	logic                            restart;

	logic [lpsp_pkg::MODE_W-1:0]     mode_pre;
	logic [lpsp_pkg::INTERVAL_W-1:0] interval_sel;
	logic [lpsp_pkg::TICK_W:0]       target_full;
	logic [lpsp_pkg::TICK_W-1:0]     target;
	logic [lpsp_pkg::TICK_W-1:0]     tick_inc;
	logic                            step_fire;
	logic [lpsp_pkg::STEP_W:0]       step_inc;
	logic [lpsp_pkg::STEP_W:0]       step_limit;
	logic [lpsp_pkg::TICK_W-1:0]     tick_nx;
	logic [lpsp_pkg::PWM_W-1:0]      pwm_inc;
	logic [lpsp_pkg::PWM_W-1:0]      pwm_nx;
	logic [lpsp_pkg::MODE_W-1:0]     mode_nx;
	logic [lpsp_pkg::STEP_W-1:0]     step_nx;
	logic [lpsp_pkg::LED_W-1:0]      mask;
	logic [lpsp_pkg::LED_W-1:0]      drive_nx;

	assign run     = s_tdata[0];
	assign duty    = s_tdata[7:1];
	assign restart = s_tdata[8];

	assign s_tready = !out_valid_q || m_tready;
	assign in_xfer  = s_tvalid && s_tready;

	always_comb begin
		mode_pre     = restart ? lpsp_pkg::MODE_WALK_LEFT : mode_q;
		interval_sel = interval_q[mode_pre];
		// interval * 10, saturated to the tick counter range
		target_full  = ({4'd0, interval_sel} << 3) + ({4'd0, interval_sel} << 1);
		target       = target_full[lpsp_pkg::TICK_W] ? lpsp_pkg::TICK_MAX
		             : target_full[lpsp_pkg::TICK_W-1:0];
		tick_inc     = tick_q + 1'b1;
		step_fire    = tick_inc >= target;
		step_inc     = {1'b0, step_q} + 1'b1;
		step_limit   = (mode_pre == lpsp_pkg::MODE_WALK_LEFT ||
		                mode_pre == lpsp_pkg::MODE_WALK_RIGHT) ? lpsp_pkg::STEPS_WALK
		             : lpsp_pkg::STEPS_PAIR;
		pwm_inc      = pwm_q + 1'b1;

		tick_nx = '0;
		pwm_nx  = '0;
		mode_nx = mode_pre;
		step_nx = step_q;
		if (run) begin
			tick_nx = step_fire ? '0 : tick_inc;
			pwm_nx  = (pwm_inc >= lpsp_pkg::PWM_WRAP) ? '0 : pwm_inc;
			if (step_fire) begin
				if (step_inc >= step_limit) begin
					step_nx = '0;
					mode_nx = mode_pre + 1'b1;
				end else begin
					step_nx = step_inc[lpsp_pkg::STEP_W-1:0];
				end
			end
		end
	end

	lpsp_mask u_mask (
		.mode (mode_nx),
		.step (step_nx),
		.mask (mask)
	);

	assign drive_nx = (run && (pwm_nx < duty)) ? ~mask : 8'hFF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				interval_q[i] <= lpsp_pkg::INTERVAL_DEFAULT;
			end
		end else if (cfg_we) begin
			interval_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			pwm_q  <= '0;
			mode_q <= lpsp_pkg::MODE_WALK_LEFT;
			step_q <= '0;
		end else if (in_xfer) begin
			tick_q <= tick_nx;
			pwm_q  <= pwm_nx;
			mode_q <= mode_nx;
			step_q <= step_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			led_q     <= drive_nx;
			pat_out_q <= mode_nx;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, pat_out_q, led_q};

	// ---- assertions ----
	a_pwm_range: assert property (@(posedge clk) disable iff (!arst_n)
		pwm_q < lpsp_pkg::PWM_WRAP)
		else $error("pwm counter out of range");

	a_pair_step: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == lpsp_pkg::MODE_PAIR_IN || mode_q == lpsp_pkg::MODE_PAIR_OUT)
		|-> step_q < lpsp_pkg::STEPS_PAIR[lpsp_pkg::STEP_W-1:0])
		else $error("pair pattern step beyond last");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !run) |=> (tick_q == '0 && pwm_q == '0 && led_q == 8'hFF))
		else $error("stopped tick did not clear counters or blank LEDs");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with empty output register");

endmodule
